// File: rtl/tbmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbmf_pkg
// Shared types and constants for the thermal background model unit.
// ----------------------------------------------------------------------------
package tbmf_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ALU_A_W     = 64;
  localparam int ALU_B_W     = 34;
  localparam int ALU_R_W     = 82;

  localparam logic [1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [1:0] MODE_RESTART = 2'd1;
  localparam logic [1:0] MODE_FOLD    = 2'd2;

  localparam logic [7:0]  AVG_FRAMES_RESET = 8'd16;
  localparam logic [47:0] MAX48            = {48{1'b1}};

  localparam logic [6:0] MUL_STEPS  = 7'd34;
  localparam logic [6:0] DIV_STEPS  = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd32;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic               start;
    alu_op_t            op;
    logic [ALU_A_W-1:0] opa;
    logic [ALU_B_W-1:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic [ALU_R_W-1:0] res;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EVAL,
    ST_W_DIV,
    ST_W_AFT,
    ST_W_MUL,
    ST_FRAME,
    ST_Z_RD,
    ST_Z_LD,
    ST_Z_DIV,
    ST_Z_SQ,
    ST_F_RD,
    ST_F_LD,
    ST_F_M1,
    ST_F_N1,
    ST_F_D1,
    ST_F_M2,
    ST_F_D2,
    ST_PUSH
  } state_t;

endpackage

// File: rtl/tbmf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbmf_if
// Handshake channels: pixel input, result output and configuration write.
// ----------------------------------------------------------------------------
interface tbmf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [5:0]         pixel_index;
  logic signed [15:0] temperature;
  logic               last_of_frame;

  modport source (output valid, mode, pixel_index, temperature, last_of_frame,
                  input ready);
  modport sink   (input valid, mode, pixel_index, temperature, last_of_frame,
                  output ready);
endinterface

interface tbmf_out_if;
  logic               valid;
  logic               ready;
  logic               foreground;
  logic               building;
  logic signed [15:0] background_mean;
  logic [15:0]        background_spread;
  logic [7:0]         frames_done;

  modport source (output valid, foreground, building, background_mean,
                  background_spread, frames_done, input ready);
  modport sink   (input valid, foreground, building, background_mean,
                  background_spread, frames_done, output ready);
endinterface

interface tbmf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/tbmf_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbmf_alu
// Shared multi-cycle unit: shift-add multiply, restoring divide, integer sqrt.
// ----------------------------------------------------------------------------
module tbmf_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  tbmf_pkg::alu_req_t req,
  output tbmf_pkg::alu_rsp_t rsp
);
  import tbmf_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [6:0]         cnt_r;
  alu_op_t            op_r;
  logic [ALU_R_W-1:0] acc_r;
  logic [63:0]        work_r;
  logic [34:0]        rem_r;
  logic [8:0]         dv_r;

  logic [48:0] mul_sum;
  logic [9:0]  div_t;
  logic        div_ge;
  logic [9:0]  div_rem;
  logic [34:0] sq_t;
  logic [34:0] sq_trial;
  logic        sq_ge;
  logic [34:0] sq_rem;

  always_comb begin
    mul_sum  = {1'b0, acc_r[81:34]} + (acc_r[0] ? {1'b0, work_r[47:0]} : 49'd0);
    div_t    = {rem_r[8:0], acc_r[63]};
    div_ge   = div_t >= {1'b0, dv_r};
    div_rem  = div_ge ? div_t - {1'b0, dv_r} : div_t;
    sq_t     = {rem_r[32:0], work_r[63:62]};
    sq_trial = {1'b0, acc_r[31:0], 2'b01};
    sq_ge    = sq_t >= sq_trial;
    sq_rem   = sq_ge ? sq_t - sq_trial : sq_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        case (req.op)
          OP_MUL:  cnt_r <= MUL_STEPS;
          OP_DIV:  cnt_r <= DIV_STEPS;
          OP_SQRT: cnt_r <= SQRT_STEPS;
          default: cnt_r <= 7'd1;
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      case (req.op)
        OP_MUL: begin
          acc_r  <= {48'd0, req.opb};
          work_r <= req.opa;
        end
        OP_DIV: begin
          acc_r <= {18'd0, req.opa};
          rem_r <= '0;
          dv_r  <= req.opb[8:0];
        end
        OP_SQRT: begin
          acc_r  <= '0;
          rem_r  <= '0;
          work_r <= req.opa;
        end
        default: acc_r <= '0;
      endcase
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: acc_r <= {mul_sum, acc_r[33:1]};
        OP_DIV: begin
          acc_r <= {acc_r[81:64], acc_r[62:0], div_ge};
          rem_r <= {25'd0, div_rem};
        end
        OP_SQRT: begin
          acc_r  <= {acc_r[81:32], acc_r[30:0], sq_ge};
          rem_r  <= sq_rem;
          work_r <= {work_r[61:0], 2'b00};
        end
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

// File: rtl/thermal_background_model_foreground_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_background_model_foreground_unit
// Per-pixel Welford background build and three-sigma foreground marking.
// ----------------------------------------------------------------------------
// Samples after the build and in the first build frame need no shared-unit
// operation; in later build frames each sample runs one 64-step divide and one
// 34-step multiply in the shared unit. The build ends with a finalize pass over
// every pixel, and a fold runs two multiplies and two divides per pixel.
// One transaction at a time; input ready only when idle.
// Reset clears the sequencer, the frame count and sets average_frames to 16;
// the pixel stores are not cleared.
module thermal_background_model_foreground_unit #(
  parameter int FRAME_COLUMNS = 16,
  parameter int FRAME_ROWS    = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  tbmf_in_if.sink    in_chan,
  tbmf_out_if.source out_chan,
  tbmf_cfg_if.sink   cfg_chan
);
  import tbmf_pkg::*;

  localparam int PIX_RAW   = FRAME_COLUMNS * FRAME_ROWS;
  localparam int PIX_COUNT = PIX_RAW > STORE_DEPTH ? STORE_DEPTH : PIX_RAW;
  localparam logic [5:0] LAST_PIX = 6'(PIX_COUNT - 1);
  localparam logic [6:0] PIX_LIM  = 7'(PIX_COUNT);

  function automatic logic [32:0] mag33(input logic [32:0] v);
    mag33 = v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic [41:0] mag42(input logic [41:0] v);
    mag42 = v[41] ? (~v + 42'd1) : v;
  endfunction

  state_t state_r, state_nxt;
  logic [7:0] af_r;
  logic [7:0] fgc_r, fgc_nxt;
  logic       out_valid_r;

  logic [1:0]  mode_r;
  logic [15:0] x_r;
  logic        last_r;
  logic        bld_r;
  logic        vld_r;
  logic [5:0]  p_r;

  logic [32:0] delta_r;
  logic [32:0] mnew_r;
  logic        opp_r;
  logic [41:0] num_r;
  logic [24:0] inc_r;

  logic        res_fg_r;
  logic [15:0] res_mean_r;
  logic [15:0] res_spr_r;

  logic        out_fg_r;
  logic        out_bld_r;
  logic [15:0] out_mean_r;
  logic [15:0] out_spr_r;
  logic [7:0]  out_frames_r;

  logic [31:0] mean_mem   [STORE_DEPTH];
  logic [47:0] spread_mem [STORE_DEPTH];
  logic [15:0] held_mem   [STORE_DEPTH];
  logic [31:0] mean_q;
  logic [47:0] spread_q;
  logic [15:0] held_q;
  logic [5:0]  rd_addr;
  logic        mean_we, spread_we, held_we;
  logic [31:0] mean_wd;
  logic [47:0] spread_wd;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  tbmf_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  logic [7:0]  a_eff, a_m1;
  logic [32:0] xs33, xh33, mean33, delta, dist_mag, w_qs, w_mnew, after, f_qs, f_mnew;
  logic [49:0] s3;
  logic [57:0] thr;
  logic        fg_now;
  logic [39:0] spr_sh;
  logic [15:0] spr_out;
  logic [57:0] term;
  logic [58:0] wsum;
  logic [47:0] wsat;
  logic [40:0] sm;
  logic [41:0] num;
  logic        in_acc, push;

  always_comb begin
    a_eff    = (af_r == 8'd0) ? 8'd1 : af_r;
    a_m1     = a_eff - 8'd1;
    xs33     = {x_r[15], x_r, 16'h0};
    xh33     = {held_q[15], held_q, 16'h0};
    mean33   = {mean_q[31], mean_q};
    delta    = xs33 - mean33;
    dist_mag = mag33(delta);
    s3       = {2'b00, spread_q} + {1'b0, spread_q, 1'b0};
    thr      = {s3, 8'h00};
    fg_now   = {25'd0, dist_mag} > thr;
    spr_sh   = spread_q[47:8];
    spr_out  = (|spr_sh[39:16]) ? 16'hFFFF : spr_sh[15:0];
    w_qs     = delta_r[32] ? (~alu_rsp.res[32:0] + 33'd1) : alu_rsp.res[32:0];
    w_mnew   = mean33 + w_qs;
    after    = xs33 - mnew_r;
    term     = opp_r ? 58'd0 : alu_rsp.res[81:24];
    wsum     = {11'd0, spread_q} + {1'b0, term};
    wsat     = (|wsum[58:48]) ? MAX48 : wsum[47:0];
    sm       = mean_q[31] ? (~{1'b0, alu_rsp.res[39:0]} + 41'd1)
                          : {1'b0, alu_rsp.res[39:0]};
    num      = {sm[40], sm} + {{9{xh33[32]}}, xh33};
    f_qs     = alu_rsp.res[32:0];
    f_mnew   = num_r[41] ? (~f_qs + 33'd1) : f_qs;
    in_acc   = in_chan.valid && (state_r == ST_IDLE);
    push     = (state_r == ST_PUSH) && (!out_valid_r || out_chan.ready);
    rd_addr  = (state_r == ST_IDLE) ? in_chan.pixel_index : p_r;
  end

  always_comb begin
    state_nxt = state_r;
    fgc_nxt   = fgc_r;
    alu_req   = '0;
    mean_we   = 1'b0;
    spread_we = 1'b0;
    held_we   = 1'b0;
    mean_wd   = '0;
    spread_wd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_PUSH;
        if (mode_r == MODE_SAMPLE) begin
          state_nxt = ST_FRAME;
          if (vld_r) begin
            held_we = 1'b1;
            if (bld_r) begin
              if (fgc_r == 8'd0) begin
                mean_we   = 1'b1;
                mean_wd   = xs33[31:0];
                spread_we = 1'b1;
              end else begin
                alu_req.start = 1'b1;
                alu_req.op    = OP_DIV;
                alu_req.opa   = {31'd0, mag33(delta)};
                alu_req.opb   = {25'd0, {1'b0, fgc_r} + 9'd1};
                state_nxt     = ST_W_DIV;
              end
            end
          end
        end else if (mode_r == MODE_RESTART) begin
          fgc_nxt = 8'd0;
        end else if (mode_r == MODE_FOLD) begin
          if (!bld_r) state_nxt = ST_F_RD;
        end
      end
      ST_W_DIV: begin
        if (alu_rsp.done) state_nxt = ST_W_AFT;
      end
      ST_W_AFT: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.opa   = {31'd0, mag33(after)};
        alu_req.opb   = {1'b0, mag33(delta_r)};
        state_nxt     = ST_W_MUL;
      end
      ST_W_MUL: begin
        if (alu_rsp.done) begin
          mean_we   = 1'b1;
          mean_wd   = mnew_r[31:0];
          spread_we = 1'b1;
          spread_wd = wsat;
          state_nxt = ST_FRAME;
        end
      end
      ST_FRAME: begin
        state_nxt = ST_PUSH;
        if (mode_r == MODE_SAMPLE && last_r && bld_r) begin
          fgc_nxt = fgc_r + 8'd1;
          if (fgc_nxt == a_eff) state_nxt = ST_Z_RD;
        end
      end
      ST_Z_RD: state_nxt = ST_Z_LD;
      ST_Z_LD: begin
        if (a_eff <= 8'd1) begin
          spread_we = 1'b1;
          state_nxt = (p_r == LAST_PIX) ? ST_PUSH : ST_Z_RD;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_DIV;
          alu_req.opa   = {16'd0, spread_q};
          alu_req.opb   = {26'd0, a_m1};
          state_nxt     = ST_Z_DIV;
        end
      end
      ST_Z_DIV: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_SQRT;
          alu_req.opa   = {alu_rsp.res[55:0], 8'h00};
          state_nxt     = ST_Z_SQ;
        end
      end
      ST_Z_SQ: begin
        if (alu_rsp.done) begin
          spread_we = 1'b1;
          spread_wd = {16'd0, alu_rsp.res[31:0]};
          state_nxt = (p_r == LAST_PIX) ? ST_PUSH : ST_Z_RD;
        end
      end
      ST_F_RD: state_nxt = ST_F_LD;
      ST_F_LD: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_MUL;
        alu_req.opa   = {31'd0, mag33(mean33)};
        alu_req.opb   = {26'd0, a_m1};
        state_nxt     = ST_F_M1;
      end
      ST_F_M1: begin
        if (alu_rsp.done) state_nxt = ST_F_N1;
      end
      ST_F_N1: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_req.opa   = {22'd0, mag42(num_r)};
        alu_req.opb   = {26'd0, a_eff};
        state_nxt     = ST_F_D1;
      end
      ST_F_D1: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_MUL;
          alu_req.opa   = {16'd0, spread_q};
          alu_req.opb   = {26'd0, a_m1};
          state_nxt     = ST_F_M2;
        end
      end
      ST_F_M2: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_DIV;
          alu_req.opa   = {8'd0, alu_rsp.res[55:0]} + {39'd0, inc_r};
          alu_req.opb   = {26'd0, a_eff};
          state_nxt     = ST_F_D2;
        end
      end
      ST_F_D2: begin
        if (alu_rsp.done) begin
          mean_we   = 1'b1;
          mean_wd   = mnew_r[31:0];
          spread_we = 1'b1;
          spread_wd = alu_rsp.res[47:0];
          state_nxt = (p_r == LAST_PIX) ? ST_PUSH : ST_F_RD;
        end
      end
      ST_PUSH: begin
        if (push) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fgc_r       <= 8'd0;
      af_r        <= AVG_FRAMES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fgc_r   <= fgc_nxt;
      if (cfg_chan.valid) af_r <= cfg_chan.data;
      if (push) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mean_we) mean_mem[p_r] <= mean_wd;
    if (spread_we) spread_mem[p_r] <= spread_wd;
    if (held_we) held_mem[p_r] <= x_r;
    mean_q   <= mean_mem[rd_addr];
    spread_q <= spread_mem[rd_addr];
    held_q   <= held_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_chan.mode;
      x_r    <= in_chan.temperature;
      last_r <= in_chan.last_of_frame;
      p_r    <= in_chan.pixel_index;
      bld_r  <= fgc_r < a_eff;
      vld_r  <= {1'b0, in_chan.pixel_index} < PIX_LIM;
    end
    case (state_r)
      ST_EVAL: begin
        delta_r    <= delta;
        res_mean_r <= vld_r ? mean_q[31:16] : 16'd0;
        res_spr_r  <= (vld_r && !bld_r) ? spr_out : 16'd0;
        res_fg_r   <= (mode_r == MODE_SAMPLE) && vld_r && !bld_r && fg_now;
      end
      ST_W_DIV: if (alu_rsp.done) mnew_r <= w_mnew;
      ST_W_AFT: opp_r <= (after[32] && !delta_r[32] && (|delta_r))
                      || (!after[32] && (|after) && delta_r[32]);
      ST_FRAME: if (mode_r == MODE_SAMPLE && last_r && bld_r && fgc_nxt == a_eff) p_r <= '0;
      ST_Z_LD: if (a_eff <= 8'd1) p_r <= p_r + 6'd1;
      ST_Z_SQ: if (alu_rsp.done) p_r <= p_r + 6'd1;
      ST_F_M1: if (alu_rsp.done) num_r <= num;
      ST_F_D1: if (alu_rsp.done) mnew_r <= f_mnew;
      ST_F_M2: inc_r <= 25'(mag33(xh33 - mnew_r) >> 8);
      ST_F_D2: if (alu_rsp.done) p_r <= p_r + 6'd1;
      default: ;
    endcase
    if (state_r == ST_EVAL && mode_r == MODE_FOLD && !bld_r) p_r <= '0;
    if (push) begin
      out_fg_r     <= res_fg_r;
      out_bld_r    <= bld_r;
      out_mean_r   <= res_mean_r;
      out_spr_r    <= res_spr_r;
      out_frames_r <= (fgc_r < a_eff) ? fgc_r : a_eff;
    end
  end

  assign in_chan.ready              = (state_r == ST_IDLE);
  assign cfg_chan.ready             = 1'b1;
  assign out_chan.valid             = out_valid_r;
  assign out_chan.foreground        = out_fg_r;
  assign out_chan.building          = out_bld_r;
  assign out_chan.background_mean   = out_mean_r;
  assign out_chan.background_spread = out_spr_r;
  assign out_chan.frames_done       = out_frames_r;

endmodule
